// File: hdl/gamepad_serial_poller_defines.svh
// assertion macros shared by the gamepad poller rtl
`ifndef GAMEPAD_SERIAL_POLLER_DEFINES_SVH
`define GAMEPAD_SERIAL_POLLER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk, quiet during reset
`define GSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gamepad poller check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define GSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gamepad poller check failed");

`else

`define GSP_ASSERT_IMP(lbl, ante, cons)
`define GSP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/gsp_pkg.sv
// types, constants and command tables of the gamepad poller
package gsp_pkg;

	localparam int POLL_FRAME_BYTES = 21;
	localparam int ADDR_W = $clog2(POLL_FRAME_BYTES);
	localparam int BYTE_W = $clog2(POLL_FRAME_BYTES + 1);
	localparam int ENTER_LEN = 5;
	localparam int CFG_LEN = 9;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [BYTE_W-1:0] byte_cnt_t;

	// input word mode codes; the spare code behaves as a tick
	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_POLL     = 2'd1,
		MODE_INIT     = 2'd2,
		MODE_TICK_ALT = 2'd3
	} mode_t;

	// init sequencer: poll frame, then the three config frames
	typedef enum logic [3:0] {
		STEP_POLL  = 4'b0001,
		STEP_ENTER = 4'b0010,
		STEP_LOCK  = 4'b0100,
		STEP_EXIT  = 4'b1000
	} step_t;

	localparam logic [7:0] CMD_START   = 8'h01;
	localparam logic [7:0] CMD_POLL    = 8'h42;
	localparam logic [7:0] CMD_CONFIG  = 8'h43;
	localparam logic [7:0] CMD_LOCK    = 8'h44;
	localparam logic [7:0] LOCK_ANALOG = 8'h03;
	localparam logic [7:0] PAD_EXIT    = 8'h5A;

	localparam logic [7:0] ENTER_CFG [ENTER_LEN] = '{
		CMD_START, CMD_CONFIG, 8'h00, 8'h01, 8'h00
	};
	localparam logic [7:0] LOCK_CFG [CFG_LEN] = '{
		CMD_START, CMD_LOCK, 8'h00, 8'h01, LOCK_ANALOG, 8'h00, 8'h00, 8'h00, 8'h00
	};
	localparam logic [7:0] EXIT_CFG [CFG_LEN] = '{
		CMD_START, CMD_CONFIG, 8'h00, 8'h00, PAD_EXIT, PAD_EXIT, PAD_EXIT, PAD_EXIT, PAD_EXIT
	};

	// pin levels
	typedef struct packed {
		logic sel;
		logic cmd;
		logic clk;
	} pins_t;

	localparam pins_t PINS_IDLE = '{sel: 1'b1, cmd: 1'b1, clk: 1'b1};
	localparam pins_t PINS_START = '{sel: 1'b0, cmd: 1'b1, clk: 1'b1};

	// response store write request
	typedef struct packed {
		logic       we;
		addr_t      addr;
		logic [7:0] data;
	} store_wr_t;

	// per-word result leaving the link sequencer
	typedef struct packed {
		pins_t       pins;
		logic        busy;
		logic        done;
		logic [15:0] buttons;
		logic        use_mem;
		logic [7:0]  alt_byte;
	} res_t;

	// sequencer status for the top level
	typedef struct packed {
		logic  active;
		logic  next_pending;
		step_t step;
		pins_t pins;
	} link_stat_t;

	// byte sent at a given place of the current frame
	function automatic logic [7:0] tx_byte(step_t step, byte_cnt_t idx);
		logic [7:0] b;
		b = 8'h00;
		case (step)
			STEP_ENTER: begin
				if (idx < BYTE_W'(ENTER_LEN)) b = ENTER_CFG[idx[2:0]];
			end
			STEP_LOCK: begin
				if (idx < BYTE_W'(CFG_LEN)) b = LOCK_CFG[idx[3:0]];
			end
			STEP_EXIT: begin
				if (idx < BYTE_W'(CFG_LEN)) b = EXIT_CFG[idx[3:0]];
			end
			default: begin
				if (idx == BYTE_W'(0)) b = CMD_START;
				else if (idx == BYTE_W'(1)) b = CMD_POLL;
			end
		endcase
		return b;
	endfunction

	// frame length in bytes
	function automatic byte_cnt_t frame_len(step_t step);
		byte_cnt_t n;
		case (step)
			STEP_ENTER: n = BYTE_W'(ENTER_LEN);
			STEP_LOCK:  n = BYTE_W'(CFG_LEN);
			STEP_EXIT:  n = BYTE_W'(CFG_LEN);
			default:    n = BYTE_W'(POLL_FRAME_BYTES);
		endcase
		return n;
	endfunction

	// store contents right after a poll frame starts
	function automatic logic [7:0] poll_default(logic [4:0] idx);
		logic [7:0] b;
		b = 8'h00;
		if (idx == 5'd0) b = CMD_START;
		else if (idx == 5'd1) b = CMD_POLL;
		return b;
	endfunction

endpackage

// File: hdl/gsp_ifs.sv
// valid/ready channels of the gamepad poller

// input words
interface gsp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       data_in;
	logic [4:0] read_index;

	modport source (output valid, output mode, output data_in, output read_index, input ready);
	modport sink (input valid, input mode, input data_in, input read_index, output ready);
endinterface

// result words
interface gsp_rsp_if;
	logic        valid;
	logic        ready;
	logic        clock_level;
	logic        command_level;
	logic        select_n;
	logic        busy_res;
	logic        frame_done;
	logic [15:0] buttons;
	logic [7:0]  read_byte;

	modport source (output valid, output clock_level, output command_level, output select_n,
		output busy_res, output frame_done, output buttons, output read_byte, input ready);
	modport sink (input valid, input clock_level, input command_level, input select_n,
		input busy_res, input frame_done, input buttons, input read_byte, output ready);
endinterface

// configuration write
interface gsp_cfg_if;
	logic valid;
	logic ready;
	logic analog_lock;

	modport source (output valid, output analog_lock, input ready);
	modport sink (input valid, input analog_lock, output ready);
endinterface

// File: hdl/gsp_ram.sv
// generic single-port-write, registered-read memory
module gsp_ram #(
	parameter int DEPTH = 21,
	parameter int WIDTH = 8,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

// File: hdl/gsp_link.sv
// link sequencer: half-bit ticks, frame and init sequencing, store writes
module gsp_link
	import gsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [1:0] mode,
	input  logic       data_in,
	input  logic [4:0] read_index,
	input  logic       analog_lock,
	output store_wr_t  wr,
	output addr_t      rd_addr,
	output res_t       res_s1,
	output link_stat_t stat
);

	logic [7:0]  shift_q, n_shift;
	logic [2:0]  bit_q, n_bit;
	logic        phase_q, n_phase;
	byte_cnt_t   byte_q, n_byte;
	step_t       step_q, n_step;
	pins_t       pins_q, n_pins;
	logic        active_q, n_active;
	logic        lock_q, n_lock;
	logic        next_q, n_next;
	byte_cnt_t   fill_q, n_fill;
	logic        loaded_q, n_loaded;
	logic [15:0] btn_q, n_btn;

	logic       start, busy, do_begin, done;
	logic [7:0] tx, shift_new;
	store_wr_t  wr_c;
	logic       in_range, fwd, below_fill;

	assign start     = (mode == MODE_POLL) || (mode == MODE_INIT);
	assign busy      = active_q || next_q;
	assign tx        = tx_byte(step_q, byte_q);
	assign shift_new = shift_q | (8'(data_in) << bit_q);

	// next state for one word
	always_comb begin
		n_shift  = shift_q;
		n_bit    = bit_q;
		n_phase  = phase_q;
		n_byte   = byte_q;
		n_step   = step_q;
		n_pins   = pins_q;
		n_active = active_q;
		n_lock   = lock_q;
		n_next   = next_q;
		n_fill   = fill_q;
		n_loaded = loaded_q;
		n_btn    = btn_q;
		do_begin = 1'b0;
		done     = 1'b0;
		wr_c     = '0;
		if (start) begin
			if (!busy) begin
				n_step   = STEP_POLL;
				n_lock   = (mode == MODE_INIT) && analog_lock;
				do_begin = 1'b1;
			end
		end else if (!active_q) begin
			if (next_q) do_begin = 1'b1;
		end else if (!phase_q) begin
			// low phase: drive command bit
			n_pins.clk = 1'b0;
			n_pins.cmd = tx[bit_q];
			n_phase    = 1'b1;
		end else begin
			// rising phase: sample data line
			n_pins.clk = 1'b1;
			n_phase    = 1'b0;
			n_shift    = shift_new;
			n_bit      = bit_q + 3'd1;
			if (bit_q == 3'd7) begin
				n_shift = 8'h00;
				if (step_q == STEP_POLL) begin
					wr_c.we   = 1'b1;
					wr_c.addr = byte_q[ADDR_W-1:0];
					wr_c.data = shift_new;
					n_fill    = byte_q + BYTE_W'(1);
					if (byte_q == BYTE_W'(3)) n_btn[7:0] = shift_new;
					if (byte_q == BYTE_W'(4)) n_btn[15:8] = shift_new;
				end
				n_byte = byte_q + BYTE_W'(1);
				if (n_byte >= frame_len(step_q)) begin
					// frame end
					done     = 1'b1;
					n_active = 1'b0;
					n_byte   = '0;
					n_pins   = PINS_IDLE;
					case (step_q)
						STEP_POLL: begin
							if (lock_q) begin
								n_lock = 1'b0;
								n_step = STEP_ENTER;
								n_next = 1'b1;
							end else begin
								n_next = 1'b0;
							end
						end
						STEP_ENTER: begin
							n_step = STEP_LOCK;
							n_next = 1'b1;
						end
						STEP_LOCK: begin
							n_step = STEP_EXIT;
							n_next = 1'b1;
						end
						default: begin
							n_step = STEP_POLL;
							n_next = 1'b0;
						end
					endcase
				end
			end
		end
		// frame start; a poll frame reloads the store image
		if (do_begin) begin
			if (n_step == STEP_POLL) begin
				n_fill   = '0;
				n_loaded = 1'b1;
				n_btn    = 16'h0000;
			end
			n_shift  = 8'h00;
			n_bit    = 3'd0;
			n_phase  = 1'b0;
			n_byte   = '0;
			n_active = 1'b1;
			n_next   = 1'b0;
			n_pins   = PINS_START;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 8'h00;
			bit_q    <= 3'd0;
			phase_q  <= 1'b0;
			byte_q   <= '0;
			step_q   <= STEP_POLL;
			pins_q   <= PINS_IDLE;
			active_q <= 1'b0;
			lock_q   <= 1'b0;
			next_q   <= 1'b0;
			fill_q   <= '0;
			loaded_q <= 1'b0;
			btn_q    <= 16'h0000;
		end else if (accept) begin
			shift_q  <= n_shift;
			bit_q    <= n_bit;
			phase_q  <= n_phase;
			byte_q   <= n_byte;
			step_q   <= n_step;
			pins_q   <= n_pins;
			active_q <= n_active;
			lock_q   <= n_lock;
			next_q   <= n_next;
			fill_q   <= n_fill;
			loaded_q <= n_loaded;
			btn_q    <= n_btn;
		end
	end

	// store read: written entries from memory, others from the poll image
	assign in_range   = int'(read_index) < POLL_FRAME_BYTES;
	assign below_fill = int'(read_index) < int'(n_fill);
	assign fwd        = wr_c.we && in_range && (wr_c.addr == read_index[ADDR_W-1:0]);
	assign rd_addr    = read_index[ADDR_W-1:0];

	// result of this word, beside the memory read
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.pins    <= n_pins;
			res_s1.busy    <= n_active || n_next;
			res_s1.done    <= done;
			res_s1.buttons <= ~n_btn;
			res_s1.use_mem <= in_range && below_fill && !fwd;
			if (fwd) res_s1.alt_byte <= wr_c.data;
			else if (in_range && n_loaded) res_s1.alt_byte <= poll_default(read_index);
			else res_s1.alt_byte <= 8'h00;
		end
	end

	assign wr                = '{we: wr_c.we && accept, addr: wr_c.addr, data: wr_c.data};
	assign stat.active       = active_q;
	assign stat.next_pending = next_q;
	assign stat.step         = step_q;
	assign stat.pins         = pins_q;

endmodule

// File: hdl/gamepad_serial_poller.sv
// top level of the gamepad serial poller
// Drives a gamepad on a clocked serial link. Every word on req is one half-bit
// tick (mode tick), a poll-frame start or an init-sequence start, plus the
// sampled data line and an index into the stored poll response. For every
// accepted word one word leaves on rsp: pin levels, busy, frame done, the
// inverted button word and the stored byte at read_index.
// cfg writes the analog_lock bit; it is always ready and is taken at init start.
// Throughput is one word per cycle while rsp does not stall: the sequencer
// updates its state in the cycle a word is accepted, and the response store
// memory is written and read in that same cycle. An accepted word passes the
// registered memory read, then the output register, before rsp valid.
// When rsp stalls, the output register holds its word and one more word can
// still be accepted into the memory stage; req.ready then drops until rsp moves.
// Reset clears the sequencer to idle with all pins high and analog_lock to zero;
// the store reads as zeros until the first frame starts, so no clearing pass is needed.
module gamepad_serial_poller
	import gsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	gsp_req_if.sink   req,
	gsp_rsp_if.source rsp,
	gsp_cfg_if.sink   cfg
);

`include "gamepad_serial_poller_defines.svh"

	logic       analog_lock_q;
	logic       accept, adv;
	logic       valid_s1;
	store_wr_t  wr;
	addr_t      rd_addr;
	res_t       res_s1;
	link_stat_t stat;
	logic [7:0] ram_q;

	logic        valid_s2;
	pins_t       pins_s2;
	logic        busy_s2, done_s2;
	logic [15:0] buttons_s2;
	logic [7:0]  byte_s2;

	// configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) analog_lock_q <= 1'b0;
		else if (cfg.valid) analog_lock_q <= cfg.analog_lock;
	end

	// handshakes
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign accept    = req.valid && req.ready;

	gsp_link u_link (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.mode        (req.mode),
		.data_in     (req.data_in),
		.read_index  (req.read_index),
		.analog_lock (analog_lock_q),
		.wr          (wr),
		.rd_addr     (rd_addr),
		.res_s1      (res_s1),
		.stat        (stat)
	);

	gsp_ram #(
		.DEPTH (POLL_FRAME_BYTES),
		.WIDTH (8),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_q)
	);

	// memory stage and output stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) valid_s2 <= 1'b1;
			else if (rsp.ready) valid_s2 <= 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (adv) begin
			pins_s2    <= res_s1.pins;
			busy_s2    <= res_s1.busy;
			done_s2    <= res_s1.done;
			buttons_s2 <= res_s1.buttons;
			byte_s2    <= res_s1.use_mem ? ram_q : res_s1.alt_byte;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.clock_level   = pins_s2.clk;
	assign rsp.command_level = pins_s2.cmd;
	assign rsp.select_n      = pins_s2.sel;
	assign rsp.busy_res      = busy_s2;
	assign rsp.frame_done    = done_s2;
	assign rsp.buttons       = buttons_s2;
	assign rsp.read_byte     = byte_s2;

	// checks
	`GSP_ASSERT_IMP(a_sel_low_only_in_frame, !stat.pins.sel, stat.active)
	`GSP_ASSERT_IMP(a_active_not_pending, stat.active, !stat.next_pending)
	`GSP_ASSERT_IMP(a_store_write_in_poll, wr.we, stat.active && (stat.step == STEP_POLL))
	`GSP_ASSERT_IMP(a_done_pins_idle, valid_s2 && done_s2, pins_s2 == PINS_IDLE)
	`GSP_ASSERT_NEXT(a_start_opens_frame,
		accept && !stat.active && !stat.next_pending && ((req.mode == MODE_POLL) || (req.mode == MODE_INIT)),
		stat.active && !stat.pins.sel)

endmodule

// File: sim/tb_gamepad_serial_poller.sv
// testbench of the gamepad serial poller: directed and random words checked against a link predictor
module tb_gamepad_serial_poller;
	timeunit 1ns;
	timeprecision 1ps;

	import gsp_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 8;
	localparam int PHASES = 4;
	localparam int PHASE_QUOTA = 132;
	localparam int DRAIN_CYCLES = 6;
	localparam int REPORT_LIMIT = 10;

	// per phase: analog_lock setting, sender idle and receiver stall in percent
	localparam logic PHASE_LOCK [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0};
	localparam int PHASE_SEND_IDLE [PHASES] = '{0, 84, 0, 34};
	localparam int PHASE_RSP_STALL [PHASES] = '{0, 0, 84, 34};

	// one result word as seen on rsp
	typedef struct packed {
		logic        clock_level;
		logic        command_level;
		logic        select_n;
		logic        busy_res;
		logic        frame_done;
		logic [15:0] buttons;
		logic [7:0]  read_byte;
	} link_result_t;

	// one directed input word, with its expected result where typed in
	typedef struct {
		mode_t        mode;
		logic         din;
		logic [4:0]   ridx;
		bit           typed;
		link_result_t want;
	} stim_row_t;

	localparam link_result_t IDLE_WORD = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'hFFFF, 8'h00};

	// reset state, an init sequence opened, starts ignored while busy, first bit of 0x01
	stim_row_t directed_rows [23] = '{
		'{MODE_TICK,     1'b0, 5'd0,  1'b1, IDLE_WORD},
		'{MODE_TICK_ALT, 1'b1, 5'd31, 1'b1, IDLE_WORD},
		'{MODE_TICK,     1'b1, 5'd20, 1'b1, IDLE_WORD},
		'{MODE_INIT,     1'b0, 5'd0,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'hFFFF, CMD_START}},
		'{MODE_POLL,     1'b1, 5'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'hFFFF, CMD_POLL}},
		'{MODE_INIT,     1'b0, 5'd2,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'hFFFF, 8'h00}},
		'{MODE_TICK,     1'b1, 5'd0,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 16'hFFFF, CMD_START}},
		'{MODE_TICK,     1'b1, 5'd0,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'hFFFF, CMD_START}},
		'{MODE_TICK_ALT, 1'b0, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'hFFFF, CMD_POLL}},
		'{MODE_TICK,     1'b1, 5'd21, 1'b0, '0},
		'{MODE_TICK,     1'b0, 5'd3,  1'b0, '0},
		'{MODE_TICK_ALT, 1'b1, 5'd4,  1'b0, '0},
		'{MODE_TICK,     1'b0, 5'd31, 1'b0, '0},
		'{MODE_TICK,     1'b1, 5'd0,  1'b0, '0},
		'{MODE_POLL,     1'b1, 5'd5,  1'b0, '0},
		'{MODE_TICK,     1'b1, 5'd20, 1'b0, '0},
		'{MODE_TICK,     1'b0, 5'd19, 1'b0, '0},
		'{MODE_TICK,     1'b1, 5'd1,  1'b0, '0},
		'{MODE_TICK,     1'b1, 5'd2,  1'b0, '0},
		'{MODE_TICK,     1'b0, 5'd0,  1'b0, '0},
		'{MODE_TICK,     1'b1, 5'd0,  1'b0, '0},
		'{MODE_TICK,     1'b0, 5'd0,  1'b0, '0},
		'{MODE_TICK,     1'b1, 5'd0,  1'b0, '0}
	};

	logic clk;
	logic arst_n;

	gsp_req_if req_ch ();
	gsp_rsp_if rsp_ch ();
	gsp_cfg_if cfg_ch ();

	gamepad_serial_poller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// predictor copy of the link state
	logic [7:0]  mirror_store [POLL_FRAME_BYTES];
	logic [7:0]  rx_shift;
	logic [2:0]  rx_bit;
	logic        half_phase;
	int unsigned tx_index;
	step_t       cur_step;
	pins_t       link_pins;
	logic        link_active;
	logic        lock_owed;
	logic        frame_owed;
	logic        lock_setting;

	link_result_t expected_rsp_words [$];
	int unsigned  mismatch_count = 0;
	int unsigned  rsp_count = 0;
	int unsigned  sender_idle_pct = 0;
	int unsigned  rsp_stall_pct = 0;

	// byte sent at position idx of the frame for step s
	function automatic logic [7:0] outgoing_byte(step_t s, int unsigned idx);
		case (s)
			STEP_ENTER: return (idx < ENTER_LEN) ? ENTER_CFG[idx] : 8'h00;
			STEP_LOCK:  return (idx < CFG_LEN) ? LOCK_CFG[idx] : 8'h00;
			STEP_EXIT:  return (idx < CFG_LEN) ? EXIT_CFG[idx] : 8'h00;
			default:    return (idx == 0) ? CMD_START : (idx == 1) ? CMD_POLL : 8'h00;
		endcase
	endfunction

	function automatic int unsigned bytes_in_frame(step_t s);
		case (s)
			STEP_ENTER: return ENTER_LEN;
			STEP_LOCK:  return CFG_LEN;
			STEP_EXIT:  return CFG_LEN;
			default:    return POLL_FRAME_BYTES;
		endcase
	endfunction

	// select goes low; a poll frame preloads the store with the bytes it sends
	function automatic void open_frame();
		if (cur_step == STEP_POLL) begin
			for (int i = 0; i < POLL_FRAME_BYTES; i++)
				mirror_store[i] = (i == 0) ? CMD_START : (i == 1) ? CMD_POLL : 8'h00;
		end
		rx_shift = 8'h00;
		rx_bit = 3'd0;
		half_phase = 1'b0;
		tx_index = 0;
		link_active = 1'b1;
		frame_owed = 1'b0;
		link_pins = PINS_START;
	endfunction

	// all pins back high, then move on through the init steps
	function automatic void close_frame();
		link_active = 1'b0;
		tx_index = 0;
		link_pins = PINS_IDLE;
		if (cur_step == STEP_POLL && lock_owed) begin
			lock_owed = 1'b0;
			cur_step = STEP_ENTER;
			frame_owed = 1'b1;
		end else if (cur_step == STEP_ENTER) begin
			cur_step = STEP_LOCK;
			frame_owed = 1'b1;
		end else if (cur_step == STEP_LOCK) begin
			cur_step = STEP_EXIT;
			frame_owed = 1'b1;
		end else begin
			cur_step = STEP_POLL;
			frame_owed = 1'b0;
		end
	endfunction

	// one half-bit tick; returns 1 when the frame ends
	function automatic logic advance_link(logic din);
		logic [7:0] b;
		if (!link_active) begin
			if (frame_owed)
				open_frame();
			return 1'b0;
		end
		// low phase: clock low, command carries the bit
		if (!half_phase) begin
			b = outgoing_byte(cur_step, tx_index);
			link_pins.clk = 1'b0;
			link_pins.cmd = b[rx_bit];
			half_phase = 1'b1;
			return 1'b0;
		end
		// rising phase: clock high, sample the data line
		link_pins.clk = 1'b1;
		half_phase = 1'b0;
		if (din)
			rx_shift[rx_bit] = 1'b1;
		if (rx_bit != 3'd7) begin
			rx_bit = rx_bit + 3'd1;
			return 1'b0;
		end
		rx_bit = 3'd0;
		if (cur_step == STEP_POLL && tx_index < POLL_FRAME_BYTES)
			mirror_store[tx_index] = rx_shift;
		rx_shift = 8'h00;
		tx_index++;
		if (tx_index >= bytes_in_frame(cur_step)) begin
			close_frame();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// expected result of one accepted input word
	function automatic link_result_t predict_link_word(mode_t m, logic din, logic [4:0] ridx);
		link_result_t r;
		logic was_busy;
		logic done;
		was_busy = link_active || frame_owed;
		done = 1'b0;
		if (m == MODE_POLL || m == MODE_INIT) begin
			if (!was_busy) begin
				cur_step = STEP_POLL;
				lock_owed = (m == MODE_INIT) && lock_setting;
				open_frame();
			end
		end else begin
			done = advance_link(din);
		end
		r.clock_level = link_pins.clk;
		r.command_level = link_pins.cmd;
		r.select_n = link_pins.sel;
		r.busy_res = link_active || frame_owed;
		r.frame_done = done;
		r.buttons = ~{mirror_store[4], mirror_store[3]};
		r.read_byte = (ridx < POLL_FRAME_BYTES) ? mirror_store[ridx] : 8'h00;
		return r;
	endfunction

	// offer one word, wait for it to be taken, queue its expected result
	task automatic send_word(mode_t m, logic din, logic [4:0] ridx, bit typed,
		link_result_t want);
		link_result_t predicted;
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.data_in <= din;
		req_ch.read_index <= ridx;
		do @(posedge clk); while (!req_ch.ready);
		predicted = predict_link_word(m, din, ridx);
		expected_rsp_words.push_back(typed ? want : predicted);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_link();
		req_ch.valid <= 1'b0;
		while (expected_rsp_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_lock(logic v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.analog_lock <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		lock_setting = v;
	endtask

	// clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// result side: random stall, compare each taken word with the oldest expectation
	always @(posedge clk) begin : rsp_check
		link_result_t got;
		link_result_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.clock_level, rsp_ch.command_level, rsp_ch.select_n,
				rsp_ch.busy_res, rsp_ch.frame_done, rsp_ch.buttons, rsp_ch.read_byte};
			if (expected_rsp_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("rsp word %0d arrived with none expected: %p", rsp_count, got);
			end else begin
				want = expected_rsp_words.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("rsp word %0d expected clk %b cmd %b sel_n %b busy %b done %b buttons %h byte %h",
							rsp_count, want.clock_level, want.command_level, want.select_n,
							want.busy_res, want.frame_done, want.buttons, want.read_byte);
						$display("rsp word %0d actual   clk %b cmd %b sel_n %b busy %b done %b buttons %h byte %h",
							rsp_count, got.clock_level, got.command_level, got.select_n,
							got.busy_res, got.frame_done, got.buttons, got.read_byte);
					end
				end
			end
			rsp_count++;
		end
		rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// run limit
	initial begin
		#2ms;
		$display("gamepad_serial_poller: mismatch");
		$finish;
	end

	// stimulus
	initial begin
		int unsigned phase_items;
		int unsigned pick;
		bit          started;
		logic        busy;
		mode_t       m;
		logic [4:0]  ridx;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_TICK;
		req_ch.data_in = 1'b0;
		req_ch.read_index = 5'd0;
		cfg_ch.valid = 1'b0;
		cfg_ch.analog_lock = 1'b0;

		// predictor after reset
		foreach (mirror_store[i])
			mirror_store[i] = 8'h00;
		rx_shift = 8'h00;
		rx_bit = 3'd0;
		half_phase = 1'b0;
		tx_index = 0;
		cur_step = STEP_POLL;
		link_pins = PINS_IDLE;
		link_active = 1'b0;
		lock_owed = 1'b0;
		frame_owed = 1'b0;
		lock_setting = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		write_lock(PHASE_LOCK[0]);

		// directed words
		foreach (directed_rows[i])
			send_word(directed_rows[i].mode, directed_rows[i].din, directed_rows[i].ridx,
				directed_rows[i].typed, directed_rows[i].want);

		// random phases: the link keeps running across phases, random line data, noise starts
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				drain_link();
				write_lock(PHASE_LOCK[p]);
			end
			sender_idle_pct = PHASE_SEND_IDLE[p];
			rsp_stall_pct = PHASE_RSP_STALL[p];
			phase_items = 0;
			started = 1'b0;
			forever begin
				busy = link_active || frame_owed;
				if (phase_items >= PHASE_QUOTA)
					break;
				pick = $urandom_range(99);
				if (!busy) begin
					if (pick < 60) begin
						// with the lock set, the first sequence of the phase is an init
						if (PHASE_LOCK[p] && !started)
							m = MODE_INIT;
						else
							m = $urandom_range(1) ? MODE_INIT : MODE_POLL;
						started = 1'b1;
					end else begin
						m = $urandom_range(1) ? MODE_TICK : MODE_TICK_ALT;
					end
				end else if (pick < 3) begin
					m = $urandom_range(1) ? MODE_INIT : MODE_POLL;
				end else begin
					m = (pick < 90) ? MODE_TICK : MODE_TICK_ALT;
				end
				if ($urandom_range(4) == 0)
					ridx = 5'($urandom_range(31, POLL_FRAME_BYTES));
				else
					ridx = 5'($urandom_range(POLL_FRAME_BYTES - 1));
				send_word(m, 1'($urandom_range(1)), ridx, 1'b0, '0);
				phase_items++;
			end
		end

		drain_link();
		if (mismatch_count == 0)
			$display("gamepad_serial_poller: match");
		else
			$display("gamepad_serial_poller: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/gsp_pkg.sv
hdl/gsp_ifs.sv
hdl/gsp_ram.sv
hdl/gsp_link.sv
hdl/gamepad_serial_poller.sv
sim/tb_gamepad_serial_poller.sv
